[rtl/core/ecrt_pkg.sv]
package ecrt_pkg;

	localparam int unsigned USER_W   = 31;
	localparam int unsigned CODE_W   = 56;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned WIN_W    = 16;
	localparam int unsigned CODE_LEN = 7;

	localparam logic [WIN_W-1:0] WINDOW_RESET = 16'd30;

	// operation codes
	typedef enum logic [1:0] {
		OP_ADD,
		OP_CHECK,
		OP_SWEEP
	} op_t;

	// request token that walks the cell row
	typedef struct packed {
		logic              valid;
		logic [1:0]        op;
		logic [USER_W-1:0] user;
		logic [CODE_W-1:0] code;
		logic [TIME_W-1:0] now;
		logic              ok;
	} token_t;

	// zero every byte from the first zero byte on
	function automatic logic [CODE_W-1:0] normalise_code(input logic [CODE_W-1:0] c);
		logic [CODE_W-1:0] r;
		logic              ended;
		r     = '0;
		ended = 1'b0;
		for (int i = 0; i < CODE_LEN; i++) begin
			if (c[8*i +: 8] == 8'd0) begin
				ended = 1'b1;
			end
			if (!ended) begin
				r[8*i +: 8] = c[8*i +: 8];
			end
		end
		return r;
	endfunction

endpackage

[rtl/core/ecrt_if.sv]
interface ecrt_cmd_if;
	logic                          valid;
	logic                          ready;
	logic [1:0]                    operation;
	logic [ecrt_pkg::USER_W-1:0]   user_id;
	logic [ecrt_pkg::CODE_W-1:0]   code_bytes;
	logic [ecrt_pkg::TIME_W-1:0]   current_time;

	modport source (output valid, operation, user_id, code_bytes, current_time, input ready);
	modport sink (input valid, operation, user_id, code_bytes, current_time, output ready);
endinterface

interface ecrt_rsp_if;
	logic valid;
	logic ready;
	logic success;

	modport source (output valid, success, input ready);
	modport sink (input valid, success, output ready);
endinterface

[rtl/core/ecrt_cell.sv]
module ecrt_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [ecrt_pkg::WIN_W-1:0]    window,
	input  ecrt_pkg::token_t              tok_i,
	output ecrt_pkg::token_t              tok_o
);

	logic [ecrt_pkg::USER_W-1:0] user_q;
	logic [ecrt_pkg::CODE_W-1:0] code_q;
	logic [ecrt_pkg::TIME_W-1:0] time_q;
	ecrt_pkg::token_t            tok_q;
	ecrt_pkg::token_t            tok_nxt;
	logic [ecrt_pkg::TIME_W-1:0] age;
	logic                        empty;
	logic                        match;
	logic                        fresh;
	logic                        store;
	logic                        clear;

	// slot tests against the passing token
	always_comb begin
		age   = tok_i.now - time_q;
		empty = (user_q == '0);
		fresh = age[ecrt_pkg::TIME_W-1] ||
			(age < {{(ecrt_pkg::TIME_W-ecrt_pkg::WIN_W){1'b0}}, window});
		match = (tok_i.user != '0) && (user_q == tok_i.user) && (code_q == tok_i.code);
	end

	// act on the token and pass it on
	always_comb begin
		tok_nxt = tok_i;
		store   = 1'b0;
		clear   = 1'b0;
		if (tok_i.valid) begin
			unique case (tok_i.op)
				ecrt_pkg::OP_ADD: begin
					if (!tok_i.ok && tok_i.user != '0 && empty) begin
						store       = 1'b1;
						tok_nxt.ok  = 1'b1;
					end
				end
				ecrt_pkg::OP_CHECK: begin
					if (match) begin
						if (fresh) begin
							tok_nxt.ok = 1'b1;
						end else begin
							clear = 1'b1;
						end
					end
				end
				ecrt_pkg::OP_SWEEP: begin
					if (!empty && !fresh) begin
						clear = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// occupancy, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			user_q <= '0;
		end else if (store) begin
			user_q <= tok_i.user;
		end else if (clear) begin
			user_q <= '0;
		end
	end

	// stored code and stamp
	always_ff @(posedge clk) begin
		if (store) begin
			code_q <= tok_i.code;
			time_q <= tok_i.now;
		end
	end

	// token stage toward the next cell
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_nxt;
		end
	end

	assign tok_o = tok_q;

endmodule

[rtl/core/expiring_code_replay_table.sv]
// Table of one-time codes kept as a row of ENTRIES cells, one slot per cell.
// Every request (add, check, sweep) travels down the row as a token, one cell
// per clock, and each cell updates its own slot as the token passes; an add
// lands in the lowest-numbered empty slot. One request is handled at a time:
// the command is registered at the head of the row, its token passes through
// every cell of the row, and the result is held in the response register. The
// next command is taken the clock after the response has been transferred.
// The user must write the expiry window through cfg_we/cfg_wdata only while
// no request is in flight; the block itself does not enforce this.
module expiring_code_replay_table #(
	parameter int unsigned ENTRIES = 64
) (
	input  logic                       clk,
	input  logic                       arst_n,
	ecrt_cmd_if.sink                   cmd,
	ecrt_rsp_if.source                 rsp,
	input  logic                       cfg_we,
	input  logic [ecrt_pkg::WIN_W-1:0] cfg_wdata
);

	ecrt_pkg::token_t            tok [0:ENTRIES];
	ecrt_pkg::token_t            tok_q;
	logic [ENTRIES:0]            tok_valid;
	logic [ecrt_pkg::WIN_W-1:0]  window_q;
	logic                        busy_q;
	logic                        rsp_valid_q;
	logic                        success_q;
	logic                        cmd_xfer;
	logic                        rsp_xfer;

	assign cmd_xfer  = cmd.valid && cmd.ready;
	assign rsp_xfer  = rsp.valid && rsp.ready;
	assign cmd.ready = !busy_q;

	// expiry window register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= ecrt_pkg::WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	// one request in flight until its response is transferred
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (cmd_xfer) begin
			busy_q <= 1'b1;
		end else if (rsp_xfer) begin
			busy_q <= 1'b0;
		end
	end

	// token injection at the head of the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q.valid <= cmd_xfer;
			if (cmd_xfer) begin
				tok_q.op   <= cmd.operation;
				tok_q.user <= cmd.user_id;
				tok_q.code <= ecrt_pkg::normalise_code(cmd.code_bytes);
				tok_q.now  <= cmd.current_time;
				tok_q.ok   <= 1'b0;
			end
		end
	end

	assign tok[0] = tok_q;

	// row of slot cells
	for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
		ecrt_cell u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.window (window_q),
			.tok_i  (tok[i]),
			.tok_o  (tok[i+1])
		);
	end

	for (genvar i = 0; i <= ENTRIES; i++) begin : g_valid
		assign tok_valid[i] = tok[i].valid;
	end

	// response register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (tok[ENTRIES].valid) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_xfer) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (tok[ENTRIES].valid) begin
			success_q <= tok[ENTRIES].ok;
		end
	end

	assign rsp.valid   = rsp_valid_q;
	assign rsp.success = success_q;

`ifndef SYNTHESIS
	// at most one token anywhere in the row
	a_one_token: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(tok_valid))
		else $error("more than one token in the cell row");

	// a command is only taken with the row and response empty
	a_idle_on_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_xfer |-> (tok_valid == '0) && !rsp_valid_q)
		else $error("command accepted while a request is in flight");

	// a token leaving the row shows up as a response
	a_token_to_rsp: assert property (@(posedge clk) disable iff (!arst_n)
		tok[ENTRIES].valid |=> rsp_valid_q)
		else $error("token left the row without a response");

	// while a response waits, no token is moving
	a_rsp_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (tok_valid == '0))
		else $error("token in flight while a response is pending");
`endif

endmodule
